// ----- src/smpq_pkg.sv -----
`default_nettype none

package smpq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// request kinds
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PRIO_W-1:0] prio_t;

	// broadcast to every cell
	typedef struct packed {
		logic  ins_en;
		logic  rem_en;
		prio_t new_prio;
		data_t new_data;
	} cell_ctl_t;

	// one result as held in the output buffer
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		data_t               head_data;
		prio_t               head_priority;
		logic                queue_empty;
		logic [COUNT_W-1:0]  entry_count;
	} result_t;

endpackage

`default_nettype wire

// ----- src/smpq_cell.sv -----
`default_nettype none

module smpq_cell
	import smpq_pkg::*;
(
	input  wire        clk,
	input  cell_ctl_t  ctl,
	input  wire        live,
	input  wire        left_take,
	input  prio_t      left_prio,
	input  data_t      left_data,
	input  prio_t      right_prio,
	input  data_t      right_data,
	output logic       take,
	output prio_t      prio_q,
	output data_t      data_q
);

	// at or behind the insert position: empty slot or priority not below the new one
	assign take = !live || (prio_q >= ctl.new_prio);

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (take) begin
				if (left_take) begin
					prio_q <= left_prio;
					data_q <= left_data;
				end else begin
					prio_q <= ctl.new_prio;
					data_q <= ctl.new_data;
				end
			end
		end else if (ctl.rem_en) begin
			prio_q <= right_prio;
			data_q <= right_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/smpq_outbuf.sv -----
`default_nettype none

module smpq_outbuf
	import smpq_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  result_t              res,
	output logic                 full,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [STATUS_W-1:0]  status,
	output data_t                head_data,
	output prio_t                head_priority,
	output logic                 queue_empty,
	output logic [COUNT_W-1:0]   entry_count
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    take;

	assign take = out_valid_q && !out_stall;
	assign full = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign head_data     = out_q.head_data;
	assign head_priority = out_q.head_priority;
	assign queue_empty   = out_q.queue_empty;
	assign entry_count   = out_q.entry_count;

endmodule

`default_nettype wire

// ----- src/sorted_min_priority_queue_top.sv -----
// Bounded min priority queue built as a row of CAPACITY cells, each holding one
// entry in ascending priority order (signed Q16.16 compared as 32-bit signed).
// The new priority is broadcast to every cell at once, so one request
// (insert or remove-head) is taken per clock cycle while in_stall is low;
// its result is registered in the output buffer. The rate is set by the
// broadcast compare and shift in the cell row. A two-deep output buffer lets
// one more request be taken while a result waits; in_stall rises only when
// both buffer slots are occupied. Each result carries the status, the head
// entry after the request (zero when empty), the empty flag and the low five
// bits of the count. Equal priorities put the newest entry first.
`default_nettype none

module sorted_min_priority_queue_top
	import smpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 action,
	input  data_t               item_data,
	input  prio_t               item_priority,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [STATUS_W-1:0] status,
	output data_t               head_data,
	output prio_t               head_priority,
	output logic                queue_empty,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic          accept;
	logic          buf_full;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          is_full;
	logic          is_empty;
	cell_ctl_t     ctl;
	result_t       res;

	logic  live   [CAPACITY];
	logic  take   [CAPACITY];
	prio_t prio_a [CAPACITY];
	data_t data_a [CAPACITY];

	prio_t head_prio_nxt;
	data_t head_data_nxt;

	// request handshake
	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);

	// control broadcast along the row
	assign ctl.ins_en   = accept && (action == ACT_INSERT) && !is_full;
	assign ctl.rem_en   = accept && (action == ACT_REMOVE) && !is_empty;
	assign ctl.new_prio = item_priority;
	assign ctl.new_data = item_data;

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins_en) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.rem_en) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// the cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic  l_take;
		prio_t l_prio;
		data_t l_data;
		prio_t r_prio;
		data_t r_data;

		assign live[g] = (count_q > CW'(g));

		if (g == 0) begin : g_first
			assign l_take = 1'b0;
			assign l_prio = prio_a[g];
			assign l_data = data_a[g];
		end else begin : g_mid
			assign l_take = take[g-1];
			assign l_prio = prio_a[g-1];
			assign l_data = data_a[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			// nothing behind the last cell: keep own contents on a remove
			assign r_prio = prio_a[g];
			assign r_data = data_a[g];
		end else begin : g_inner
			assign r_prio = prio_a[g+1];
			assign r_data = data_a[g+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.live       (live[g]),
			.left_take  (l_take),
			.left_prio  (l_prio),
			.left_data  (l_data),
			.right_prio (r_prio),
			.right_data (r_data),
			.take       (take[g]),
			.prio_q     (prio_a[g]),
			.data_q     (data_a[g])
		);
	end

	// head as it will stand after this request
	always_comb begin
		head_prio_nxt = prio_a[0];
		head_data_nxt = data_a[0];
		if (ctl.ins_en) begin
			if (take[0]) begin
				head_prio_nxt = item_priority;
				head_data_nxt = item_data;
			end
		end else if (ctl.rem_en) begin
			head_prio_nxt = prio_a[1];
			head_data_nxt = data_a[1];
		end
	end

	always_comb begin
		res.status = ST_DONE;
		if (action == ACT_INSERT && is_full) begin
			res.status = ST_FULL;
		end else if (action == ACT_REMOVE && is_empty) begin
			res.status = ST_EMPTY;
		end
		res.queue_empty   = (count_nxt == '0);
		res.head_data     = res.queue_empty ? '0 : head_data_nxt;
		res.head_priority = res.queue_empty ? '0 : head_prio_nxt;
		res.entry_count   = COUNT_W'(count_nxt);
	end

	smpq_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (accept),
		.res           (res),
		.full          (buf_full),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.head_data     (head_data),
		.head_priority (head_priority),
		.queue_empty   (queue_empty),
		.entry_count   (entry_count)
	);

	// count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// a taken insert on a queue with room grows it by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_INSERT && !is_full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the queue");

	// a taken remove on a non-empty queue shrinks it by one
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_REMOVE && !is_empty) |=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not shrink the queue");

	// without a request the count holds
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without a request");

endmodule

`default_nettype wire
